// ===== hw/rtl/first_fit_segment_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit segment allocator
// Shared implication macros with a common clock, reset and report.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FFSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication.
`define FFSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ===== hw/rtl/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types and constants shared by the allocator controller and datapath.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int unsigned PoolW  = 16;
  localparam int unsigned HdrW   = 8;
  localparam int unsigned CodeW  = 3;
  localparam logic [PoolW-1:0] PoolReset = 16'd4096;
  localparam logic [HdrW-1:0]  HdrReset  = 8'd24;

  // Configuration register indexes.
  localparam logic CfgPool = 1'b0;
  localparam logic CfgHdr  = 1'b1;

  // Request functions.
  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  typedef enum logic [CodeW-1:0] {
    RES_OK       = 3'd0,
    RES_NO_FIT   = 3'd1,
    RES_FULL     = 3'd2,
    RES_NOT_FND  = 3'd3,
    RES_ALR_FREE = 3'd4
  } result_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE_N,
    ST_FREE_P
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic grant;
    logic split;
    logic mark_free;
    logic merge_next;
    logic merge_prev;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end;
    logic func;
    logic fit;
    logic tight;
    logic full;
    logic hit;
    logic is_free;
    logic next_ok;
    logic prev_ok;
  } sts_t;

endpackage

// ===== hw/rtl/ffsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer that walks the segment table and issues datapath commands.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  ffsa_pkg::sts_t sts_i,
  output ffsa_pkg::cmd_t cmd_o,
  output logic           done_o,
  output logic [2:0]     code_o
);
  import ffsa_pkg::*;
  `include "first_fit_segment_allocator_unit_assert.svh"

  state_e  state_q, state_d;
  logic    done_q, done_d;
  result_e code_q, code_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.at_end) begin
          state_d = ST_IDLE;
        end else if (sts_i.func == FuncAlloc) begin
          if (sts_i.fit) state_d = ST_IDLE;
        end else if (sts_i.hit) begin
          state_d = sts_i.is_free ? ST_IDLE : ST_FREE_N;
        end
      end
      ST_FREE_N: state_d = ST_FREE_P;
      ST_FREE_P: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands and result.
  always_comb begin
    cmd_o  = '0;
    done_d = 1'b0;
    code_d = RES_OK;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_SCAN: begin
        if (sts_i.at_end) begin
          done_d = 1'b1;
          code_d = (sts_i.func == FuncAlloc) ? RES_NO_FIT : RES_NOT_FND;
        end else if (sts_i.func == FuncAlloc) begin
          if (!sts_i.fit) begin
            cmd_o.step = 1'b1;
          end else if (sts_i.tight) begin
            cmd_o.grant = 1'b1;
            done_d      = 1'b1;
          end else if (sts_i.full) begin
            done_d = 1'b1;
            code_d = RES_FULL;
          end else begin
            cmd_o.split = 1'b1;
            done_d      = 1'b1;
          end
        end else if (!sts_i.hit) begin
          cmd_o.step = 1'b1;
        end else if (sts_i.is_free) begin
          done_d = 1'b1;
          code_d = RES_ALR_FREE;
        end
      end
      ST_FREE_N: begin
        cmd_o.mark_free  = 1'b1;
        cmd_o.merge_next = sts_i.next_ok;
      end
      ST_FREE_P: begin
        cmd_o.merge_prev = sts_i.prev_ok;
        done_d           = 1'b1;
      end
      default: ;
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      code_q  <= RES_OK;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      code_q  <= code_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign code_o = code_q;

  `FFSA_ASSERT_IMP(a_done_idle, done_q, state_q == ST_IDLE)
  `FFSA_ASSERT_NXT(a_start_scan, start_i && !busy_o, state_q == ST_SCAN)
  `FFSA_ASSERT_NXT(a_free_seq, state_q == ST_FREE_N, state_q == ST_FREE_P)

endmodule

// ===== hw/rtl/ffsa_dp.sv =====
// ----------------------------------------------------------------------------
// ffsa_dp
// Segment table, configuration registers and request operands.
// ----------------------------------------------------------------------------
module ffsa_dp #(
  parameter int unsigned MaxSegments = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           func_i,
  input  logic [15:0]    req_bytes_i,
  input  logic [15:0]    free_addr_i,
  input  ffsa_pkg::cmd_t cmd_i,
  output ffsa_pkg::sts_t sts_o,
  output logic [15:0]    block_addr_o
);
  import ffsa_pkg::*;
  `include "first_fit_segment_allocator_unit_assert.svh"

  localparam int unsigned IW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned CW = $clog2(MaxSegments + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxSegments);

  logic [PoolW-1:0] pool_q, pool_d;
  logic [HdrW-1:0]  hdr_q, hdr_d;
  logic             func_q;
  logic [15:0]      req_q, faddr_q, addr_q;
  logic [CW-1:0]    idx_q, cnt_q, idx_inc;
  logic [15:0]      start_q [MaxSegments];
  logic [15:0]      size_q  [MaxSegments];
  logic             free_q  [MaxSegments];
  logic [IW-1:0]    ci, ni, pi;
  logic [16:0]      need;
  logic [15:0]      cur_start, cur_size, init_size;

  // Configuration values as they stand after this cycle's write.
  always_comb begin
    pool_d = pool_q;
    hdr_d  = hdr_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == CfgPool) pool_d = cfg_wdata_i;
      else                      hdr_d  = cfg_wdata_i[HdrW-1:0];
    end
  end
  assign init_size = (pool_d >= {8'd0, hdr_d}) ? pool_d - {8'd0, hdr_d} : 16'd0;

  // Read ports at the scan position and its neighbours.
  assign idx_inc   = idx_q + CW'(1);
  assign ci        = idx_q[IW-1:0];
  assign ni        = idx_inc[IW-1:0];
  assign pi        = ci - IW'(1);
  assign cur_start = start_q[ci];
  assign cur_size  = size_q[ci];
  assign need      = {1'b0, req_q} + {9'd0, hdr_q};

  always_comb begin
    sts_o         = '0;
    sts_o.at_end  = (idx_q >= cnt_q);
    sts_o.func    = func_q;
    sts_o.fit     = free_q[ci] && (cur_size >= req_q);
    sts_o.tight   = ({1'b0, cur_size} < need);
    sts_o.full    = (cnt_q == CntMax);
    sts_o.hit     = (cur_start == faddr_q);
    sts_o.is_free = free_q[ci];
    sts_o.next_ok = (idx_inc < cnt_q) && free_q[ni];
    sts_o.prev_ok = (idx_q != '0) && free_q[pi];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= PoolReset;
      hdr_q  <= HdrReset;
      cnt_q  <= CW'(1);
      idx_q  <= '0;
    end else begin
      pool_q <= pool_d;
      hdr_q  <= hdr_d;
      if (cfg_we_i)                          cnt_q <= CW'(1);
      else if (cmd_i.split)                  cnt_q <= cnt_q + CW'(1);
      else if (cmd_i.merge_next || cmd_i.merge_prev) cnt_q <= cnt_q - CW'(1);
      if (cmd_i.load)      idx_q <= '0;
      else if (cmd_i.step) idx_q <= idx_inc;
    end
  end

  // Request operands and granted address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      req_q   <= req_bytes_i;
      faddr_q <= free_addr_i;
      addr_q  <= '0;
    end else if (cmd_i.grant || cmd_i.split) begin
      addr_q  <= cur_start;
    end
  end

  // Segment table: insertion and removal move the entries behind the affected one by one place.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q[0] <= {8'd0, HdrReset};
      size_q[0]  <= PoolReset - {8'd0, HdrReset};
      free_q[0]  <= 1'b1;
    end else if (cfg_we_i) begin
      start_q[0] <= {8'd0, hdr_d};
      size_q[0]  <= init_size;
      free_q[0]  <= 1'b1;
    end else if (cmd_i.grant) begin
      free_q[ci] <= 1'b0;
    end else if (cmd_i.split) begin
      for (int j = 1; j < MaxSegments; j++) begin
        if (j > int'(idx_q) + 1 && j <= int'(cnt_q)) begin
          start_q[j] <= start_q[j-1];
          size_q[j]  <= size_q[j-1];
          free_q[j]  <= free_q[j-1];
        end
      end
      size_q[ci]  <= req_q;
      free_q[ci]  <= 1'b0;
      start_q[ni] <= cur_start + need[15:0];
      size_q[ni]  <= cur_size - need[15:0];
      free_q[ni]  <= 1'b1;
    end else if (cmd_i.merge_next) begin
      for (int j = 0; j < MaxSegments - 1; j++) begin
        if (j > int'(idx_q)) begin
          start_q[j] <= start_q[j+1];
          size_q[j]  <= size_q[j+1];
          free_q[j]  <= free_q[j+1];
        end
      end
      size_q[ci] <= cur_size + size_q[ni] + {8'd0, hdr_q};
      free_q[ci] <= 1'b1;
    end else if (cmd_i.mark_free) begin
      free_q[ci] <= 1'b1;
    end else if (cmd_i.merge_prev) begin
      for (int j = 0; j < MaxSegments - 1; j++) begin
        if (j >= int'(idx_q)) begin
          start_q[j] <= start_q[j+1];
          size_q[j]  <= size_q[j+1];
          free_q[j]  <= free_q[j+1];
        end
      end
      size_q[pi] <= size_q[pi] + cur_size + {8'd0, hdr_q};
    end
  end

  assign block_addr_o = addr_q;

  `FFSA_ASSERT_IMP(a_cnt_range, 1'b1, (cnt_q != '0) && (cnt_q <= CntMax))
  `FFSA_ASSERT_IMP(a_split_room, cmd_i.split, !sts_o.full)
  `FFSA_ASSERT_NXT(a_load_idx, cmd_i.load, idx_q == '0)

endmodule

// ===== hw/rtl/first_fit_segment_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// First-fit allocator over an address-ordered segment table with coalescing.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// request   in         start_i, busy_o         func_i, req_bytes_i, free_addr_i
// result    out        done_o (one cycle)      result_code_o, block_addr_o
// config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// The controller inspects one table entry per cycle, so the walk over the
// table sets how long an item takes. The result strobe is registered and
// rises in the cycle after the last step; busy_o is low again then.
// Reset leaves one free segment spanning the pool; a configuration write
// does the same at once. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_unit #(
  parameter int unsigned MaxSegments = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        func_i,
  input  logic [15:0] req_bytes_i,
  input  logic [15:0] free_addr_i,
  output logic        done_o,
  output logic [2:0]  result_code_o,
  output logic [15:0] block_addr_o
);
  import ffsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .done_o  (done_o),
    .code_o  (result_code_o)
  );

  ffsa_dp #(
    .MaxSegments (MaxSegments)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .func_i       (func_i),
    .req_bytes_i  (req_bytes_i),
    .free_addr_i  (free_addr_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .block_addr_o (block_addr_o)
  );

endmodule

// ===== tb/tb_first_fit_segment_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Testbench for first_fit_segment_allocator_unit
// Drives allocate and free requests through the command port, runs several
// pool and header settings, and checks every result against a table model
// of the allocator kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_fit_segment_allocator_unit;
  import ffsa_pkg::*;

  localparam int unsigned MaxSeg    = 16;
  localparam int unsigned WatchLimit = 2000;

  // Register settings for the random phases, one pair per phase.
  localparam logic [15:0] PoolSet [8] = '{16'd65535, 16'd0, 16'd100, 16'd1024,
                                          16'd512, 16'd65535, 16'd300, 16'd4096};
  localparam logic [7:0]  HdrSet [8]  = '{8'd255, 8'd0, 8'd255, 8'd8,
                                          8'd16, 8'd0, 8'd255, 8'd24};

  // Table model of the allocator and the queue of expected results.
  class alloc_scoreboard;
    logic [15:0] pool;
    logic [7:0]  hdr;
    logic [15:0] seg_base[MaxSeg];
    logic [15:0] seg_len[MaxSeg];
    bit          seg_avail[MaxSeg];
    int unsigned seg_cnt;
    result_e     exp_code[$];
    logic [15:0] exp_addr[$];
    int unsigned errors;
    int unsigned n_alloc, n_free;
    int unsigned code_seen[5];

    function void clear_table();
      foreach (seg_base[i]) begin
        seg_base[i] = '0;
        seg_len[i] = '0;
        seg_avail[i] = 1'b0;
      end
      seg_base[0] = {8'd0, hdr};
      seg_len[0] = (pool >= hdr) ? pool - hdr : '0;
      seg_avail[0] = 1'b1;
      seg_cnt = 1;
    endfunction

    function void configure(logic idx, logic [15:0] val);
      if (idx == CfgPool) pool = val;
      else hdr = val[7:0];
      clear_table();
    endfunction

    function void drop_entry(int unsigned k);
      for (int unsigned i = k; i + 1 < seg_cnt; i++) begin
        seg_base[i] = seg_base[i+1];
        seg_len[i] = seg_len[i+1];
        seg_avail[i] = seg_avail[i+1];
      end
      seg_cnt--;
    endfunction

    // An accepted item: work out its result and queue it.
    function void note(logic fn, logic [15:0] req, logic [15:0] faddr);
      result_e     code;
      logic [15:0] addr;
      int unsigned i;
      code = RES_NO_FIT;
      addr = '0;
      if (fn == FuncAlloc) begin
        n_alloc++;
        for (i = 0; i < seg_cnt; i++) begin
          if (!seg_avail[i] || seg_len[i] < req) continue;
          if ({1'b0, seg_len[i]} < {1'b0, req} + hdr) begin
            seg_avail[i] = 1'b0;
            addr = seg_base[i];
            code = RES_OK;
            break;
          end
          if (seg_cnt >= MaxSeg) begin
            code = RES_FULL;
            break;
          end
          for (int unsigned j = seg_cnt; j > i; j--) begin
            seg_base[j] = seg_base[j-1];
            seg_len[j] = seg_len[j-1];
            seg_avail[j] = seg_avail[j-1];
          end
          seg_cnt++;
          seg_len[i+1] = seg_len[i] - req - hdr;
          seg_base[i+1] = seg_base[i] + req + hdr;
          seg_avail[i+1] = 1'b1;
          seg_len[i] = req;
          seg_avail[i] = 1'b0;
          addr = seg_base[i];
          code = RES_OK;
          break;
        end
      end else begin
        n_free++;
        for (i = 0; i < seg_cnt; i++)
          if (seg_base[i] == faddr) break;
        if (i >= seg_cnt) code = RES_NOT_FND;
        else if (seg_avail[i]) code = RES_ALR_FREE;
        else begin
          code = RES_OK;
          seg_avail[i] = 1'b1;
          if (i + 1 < seg_cnt && seg_avail[i+1]) begin
            seg_len[i] = seg_len[i] + seg_len[i+1] + hdr;
            drop_entry(i + 1);
          end
          if (i > 0 && seg_avail[i-1]) begin
            seg_len[i-1] = seg_len[i-1] + seg_len[i] + hdr;
            drop_entry(i);
          end
        end
      end
      exp_code.push_back(code);
      exp_addr.push_back(addr);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // A result strobe: compare with the oldest expectation.
    task check(logic [2:0] code, logic [15:0] addr);
      result_e     ec;
      logic [15:0] ea;
      if (exp_code.size() == 0) begin
        report($sformatf("result code %0d addr %h with nothing expected", code, addr));
        return;
      end
      ec = exp_code.pop_front();
      ea = exp_addr.pop_front();
      if (ec < 5) code_seen[ec]++;
      if (code !== ec)
        report($sformatf("result_code %0d, expected %0d (%s)", code, ec, ec.name()));
      if (addr !== ea)
        report($sformatf("block_addr %h, expected %h", addr, ea));
    endtask

    function logic [15:0] some_start();
      return seg_base[$urandom_range(0, seg_cnt - 1)];
    endfunction

    function logic [15:0] some_free_len();
      for (int unsigned i = 0; i < seg_cnt; i++)
        if (seg_avail[i] && $urandom_range(0, 1)) return seg_len[i];
      return seg_len[0];
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i, cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        start_i, busy_o, func_i;
  logic [15:0] req_bytes_i, free_addr_i;
  logic        done_o;
  logic [2:0]  result_code_o;
  logic [15:0] block_addr_o;

  alloc_scoreboard sb;
  bit          idle_on;
  int unsigned quiet_cycles;
  int unsigned n_cfg;

  first_fit_segment_allocator_unit #(.MaxSegments(MaxSeg)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .start_i, .busy_o, .func_i, .req_bytes_i, .free_addr_i,
    .done_o, .result_code_o, .block_addr_o
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Monitor: results are checked before a new item is noted, as both can
  // fall on one edge. The watchdog counts edges with no handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check(result_code_o, block_addr_o);
      if (start_i && !busy_o) sb.note(func_i, req_bytes_i, free_addr_i);
      if (done_o || (start_i && !busy_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("watchdog: no handshake for %0d cycles", WatchLimit);
        $display("** first_fit_segment_allocator_unit: FAILED **");
        $finish;
      end
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(logic fn, logic [15:0] req, logic [15:0] faddr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    func_i <= fn;
    req_bytes_i <= req;
    free_addr_i <= faddr;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
  endtask

  // Wait until every result is in and the block is idle.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.exp_code.size() != 0) @(posedge clk_i);
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
  endtask

  // One register write, with the write enable low ahead of it so that writes
  // back to back each get their own strobe.
  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.configure(idx, val);
    cfg_we_i <= 1'b0;
    n_cfg++;
  endtask

  task automatic random_items(int unsigned n);
    logic [15:0] req, faddr;
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 5))
          0, 1: req = 16'($urandom_range(0, 63));
          2:    req = 16'($urandom_range(0, sb.pool / 4));
          3:    req = sb.some_free_len();
          4:    req = 16'(sb.some_free_len() - $urandom_range(0, 3));
          default: req = 16'($urandom_range(0, 16'hffff));
        endcase
        send_item(FuncAlloc, req, 16'($urandom_range(0, 16'hffff)));
      end else begin
        case ($urandom_range(0, 7))
          0:       faddr = 16'($urandom_range(0, 16'hffff));
          1:       faddr = 16'(sb.some_start() + 16'd1);
          default: faddr = sb.some_start();
        endcase
        send_item(FuncFree, 16'($urandom_range(0, 16'hffff)), faddr);
      end
    end
  endtask

  // Stimulus.
  initial begin
    sb = new();
    sb.pool = PoolReset;
    sb.hdr = HdrReset;
    sb.clear_table();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgPool;
    cfg_wdata_i = '0;
    start_i = 1'b0;
    func_i = FuncAlloc;
    req_bytes_i = '0;
    free_addr_i = '0;
    idle_on = 1'b1;
    quiet_cycles = 0;
    n_cfg = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: splits, merges on both sides, missing and repeated frees,
    // a zero request, an oversized one and a full table.
    send_item(FuncAlloc, 16'd100, '0);
    send_item(FuncAlloc, 16'd200, '0);
    send_item(FuncAlloc, 16'd300, '0);
    send_item(FuncFree, '0, 16'd148);
    send_item(FuncFree, '0, 16'd148);
    send_item(FuncFree, '0, 16'd24);
    send_item(FuncFree, '0, 16'd372);
    send_item(FuncFree, '0, 16'hffff);
    send_item(FuncAlloc, 16'hffff, '0);
    send_item(FuncAlloc, 16'd0, '0);
    for (int i = 0; i < 16; i++) send_item(FuncAlloc, 16'd1, '0);
    send_item(FuncFree, '0, 16'd0);
    drain();

    // Random phases, each with a fresh setting of both registers.
    foreach (PoolSet[p]) begin
      write_reg(CfgPool, PoolSet[p]);
      write_reg(CfgHdr, {8'd0, HdrSet[p]});
      if (p == 7) idle_on = 1'b0;
      random_items(90);
      if (p == 3) drain();
      random_items(90);
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("covered %0d allocate and %0d free requests over %0d register writes",
             sb.n_alloc, sb.n_free, n_cfg);
    $display("results: ok %0d, no fit %0d, full %0d, not found %0d, already free %0d",
             sb.code_seen[0], sb.code_seen[1], sb.code_seen[2], sb.code_seen[3],
             sb.code_seen[4]);
    if (sb.errors == 0 && sb.exp_code.size() == 0)
      $display("** first_fit_segment_allocator_unit: PASSED **");
    else
      $display("** first_fit_segment_allocator_unit: FAILED **");
    $finish;
  end

endmodule
